@@ rtl/core/tdpt_pkg.sv @@
// Package for the trial-division prime test: widths, states and divider interface.
`timescale 1ns / 1ps

package tdpt_pkg;

  // Width at which the candidate is tested (8 to 64).
  localparam int VALUE_WIDTH = 32;
  // Widths of the candidate and echoed value ports.
  localparam int IN_W  = 32;
  localparam int OUT_W = 32;
  // Width that holds any port value or any tested value.
  localparam int EXT_W = 64;
  // Width of the divider step counter.
  localparam int CNT_W = $clog2(VALUE_WIDTH);

  typedef logic [VALUE_WIDTH-1:0] value_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_START = 4'b0010,
    S_WAIT  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  typedef struct packed {
    logic   start;
    value_t dividend;
    value_t divisor;
  } div_req_t;

  typedef struct packed {
    logic   done;
    value_t quotient;
    value_t remainder;
  } div_rsp_t;

endpackage

@@ rtl/core/tdpt_divider.sv @@
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module tdpt_divider (
  input  logic              clk,
  input  logic              rst,
  input  tdpt_pkg::div_req_t req,
  output tdpt_pkg::div_rsp_t rsp
);

  localparam int VW = tdpt_pkg::VALUE_WIDTH;

  logic                      busy;
  logic                      done;
  logic [tdpt_pkg::CNT_W-1:0] cnt;
  tdpt_pkg::value_t          rem;
  tdpt_pkg::value_t          quo;
  tdpt_pkg::value_t          dsr;

  logic [VW:0]      trial;
  logic [VW:0]      diff;
  logic             qbit;
  tdpt_pkg::value_t rem_next;

  // The dividend shifts out of quo from the top while quotient bits enter at the bottom.
  always_comb begin
    trial    = {rem, quo[VW-1]};
    diff     = trial - {1'b0, dsr};
    qbit     = ~diff[VW];
    rem_next = qbit ? diff[VW-1:0] : trial[VW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == tdpt_pkg::CNT_W'(VW - 1))) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt <= '0;
      rem <= '0;
      quo <= req.dividend;
      dsr <= req.divisor;
    end else if (busy) begin
      cnt <= cnt + tdpt_pkg::CNT_W'(1);
      rem <= rem_next;
      quo <= {quo[VW-2:0], qbit};
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

@@ rtl/core/trial_division_prime_test_unit.sv @@
// Top level of the trial-division prime test: sequencer, divider and output register.
`timescale 1ns / 1ps

// Usage:
// An item enters on in_valid/in_ready carrying candidate; the low VALUE_WIDTH bits
// are tested. Exactly one result leaves on out_valid/out_ready with tested_value
// (the tested value) and is_prime. The value 2 is prime, 0 and 1 are not.
// Even values and 0 to 2 are settled without a trial: idle goes straight to done.
// An odd value runs trials with divisors 3, 5, 7, ... on one shared restoring
// divider; each trial is a start step, one quotient bit per cycle, and a
// decision. A trial stops the test when the divisor exceeds the quotient (prime)
// or the remainder is zero (composite).
// One item is worked at a time: in_ready is high only while the sequencer is idle.
// A finished result sits in an output register; in_ready rises again as soon as it
// is loaded, so the next item starts while the result waits. If the receiver
// stalls and a second result is ready, the sequencer holds until the register
// frees. Reset (rst, synchronous) returns the sequencer to idle and drops out_valid.

module trial_division_prime_test_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [tdpt_pkg::IN_W-1:0] candidate,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [tdpt_pkg::OUT_W-1:0] tested_value,
  output logic                      is_prime
);

  localparam int VW = tdpt_pkg::VALUE_WIDTH;

  tdpt_pkg::state_t   state;
  tdpt_pkg::state_t   state_next;
  tdpt_pkg::value_t   value;
  tdpt_pkg::value_t   divisor;
  logic               verdict;
  tdpt_pkg::div_req_t req;
  tdpt_pkg::div_rsp_t rsp;

  logic [tdpt_pkg::EXT_W-1:0] cand_ext;
  logic [tdpt_pkg::EXT_W-1:0] value_ext;
  tdpt_pkg::value_t           in_value;
  logic                       accept;
  logic                       out_load;

  tdpt_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always_comb begin
    cand_ext  = {{(tdpt_pkg::EXT_W - tdpt_pkg::IN_W){1'b0}}, candidate};
    in_value  = cand_ext[VW-1:0];
    value_ext = tdpt_pkg::EXT_W'(value);
    accept    = in_valid && in_ready;
    out_load  = (state == tdpt_pkg::S_DONE) && (!out_valid || out_ready);
  end

  assign in_ready     = (state == tdpt_pkg::S_IDLE);
  assign req.start    = (state == tdpt_pkg::S_START);
  assign req.dividend = value;
  assign req.divisor  = divisor;

  always_comb begin
    state_next = state;
    case (state)
      tdpt_pkg::S_IDLE: begin
        if (accept) begin
          // Zero, one, two and other even values need no trial.
          if (in_value[0] && (in_value != VW'(1))) begin
            state_next = tdpt_pkg::S_START;
          end else begin
            state_next = tdpt_pkg::S_DONE;
          end
        end
      end
      tdpt_pkg::S_START: begin
        state_next = tdpt_pkg::S_WAIT;
      end
      tdpt_pkg::S_WAIT: begin
        if (rsp.done) begin
          if ((divisor > rsp.quotient) || (rsp.remainder == '0)) begin
            state_next = tdpt_pkg::S_DONE;
          end else begin
            state_next = tdpt_pkg::S_START;
          end
        end
      end
      tdpt_pkg::S_DONE: begin
        if (out_load) begin
          state_next = tdpt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = tdpt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tdpt_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value   <= in_value;
      divisor <= VW'(3);
      verdict <= (in_value == VW'(2));
    end
    if ((state == tdpt_pkg::S_WAIT) && rsp.done) begin
      // The bound is checked first: a divisor past the square root means prime.
      if (divisor > rsp.quotient) begin
        verdict <= 1'b1;
      end else if (rsp.remainder == '0) begin
        verdict <= 1'b0;
      end else begin
        divisor <= divisor + VW'(2);
      end
    end
    if (out_load) begin
      tested_value <= value_ext[tdpt_pkg::OUT_W-1:0];
      is_prime     <= verdict;
    end
  end

`ifndef SYNTH
  a_divisor_odd: assert property (@(posedge clk) disable iff (rst)
    (state == tdpt_pkg::S_WAIT) |-> (divisor[0] && (divisor >= VW'(3))))
    else $error("trial divisor is not an odd value of at least three");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    ((state == tdpt_pkg::S_WAIT) && rsp.done) |-> (rsp.remainder < divisor))
    else $error("divider remainder is not below the divisor");

  a_zero_rem_composite: assert property (@(posedge clk) disable iff (rst)
    ((state == tdpt_pkg::S_WAIT) && rsp.done && (divisor <= rsp.quotient)
      && (rsp.remainder == '0)) |=> ((state == tdpt_pkg::S_DONE) && !verdict))
    else $error("exact division did not end the test as composite");

  a_load_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == tdpt_pkg::S_DONE))
    else $error("result presented without a finished test");
`endif

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the trial-division prime test unit.
`timescale 1ns / 1ps

module testbench;

  localparam int VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH;
  localparam int IN_W        = tdpt_pkg::IN_W;
  localparam int OUT_W       = tdpt_pkg::OUT_W;

  localparam int CLK_PERIOD = 10;
  // The limit leaves a wide margin over the slowest run.
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [63:0] WIDTH_MASK =
    (VALUE_WIDTH >= 64) ? '1 : ((64'd1 << VALUE_WIDTH) - 64'd1);

  typedef struct {
    logic [OUT_W-1:0] value;
    logic             prime;
  } verdict_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [IN_W-1:0]   candidate = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [OUT_W-1:0]  tested_value;
  logic              is_prime;

  logic [IN_W-1:0] candidates_to_send[$];
  verdict_t        pending_verdicts[$];
  int unsigned     send_idle_pct = 10;
  int unsigned     recv_idle_pct = 85;
  logic            start_hold = 1'b0;
  int              hold_count = 0;
  int              mismatch_count = 0;
  int              cycle_count = 0;

  trial_division_prime_test_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .candidate    (candidate),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .tested_value (tested_value),
    .is_prime     (is_prime)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic logic prime_by_trial_division(input logic [63:0] v);
    logic [63:0] d;
    if (v < 64'd2) return 1'b0;
    if (v == 64'd2) return 1'b1;
    if (!v[0]) return 1'b0;
    for (d = 64'd3; d <= v / d; d += 64'd2) begin
      if (v % d == 64'd0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic verdict_t predict_verdict(input logic [IN_W-1:0] number);
    logic [63:0] tested;
    verdict_t    verdict;
    tested = 64'(number) & WIDTH_MASK;
    verdict.value = tested[OUT_W-1:0];
    verdict.prime = prime_by_trial_division(tested);
    return verdict;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    mismatch_count++;
  endtask

  // Full-width random values must be cheap to settle: either even or a
  // multiple of three. Odd values that may be prime stay below 2^16.
  function automatic logic [IN_W-1:0] random_candidate();
    logic [IN_W-1:0] r;
    int unsigned     pick;
    pick = $urandom_range(99);
    r = $urandom;
    if (pick < 50) return IN_W'($urandom_range(65535, 3) | 1);
    if (pick < 75) return {r[IN_W-1:1], 1'b0};
    if (pick < 90) return r - (r % 3);
    return IN_W'($urandom_range(15));
  endfunction

  task automatic wait_until_drained();
    while (candidates_to_send.size() != 0 || in_valid || pending_verdicts.size() != 0)
      @(negedge clk);
  endtask

  // Driver: offers the next candidate once the current one is taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (candidates_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid  <= 1'b1;
        candidate <= candidates_to_send.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus a long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      hold_count <= 0;
    end else if (start_hold) begin
      out_ready  <= 1'b0;
      hold_count <= HOLD_CYCLES;
    end else if (hold_count > 0) begin
      out_ready  <= 1'b0;
      hold_count <= hold_count - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: predicts on each accepted candidate and checks each accepted result.
  always @(posedge clk) begin
    verdict_t want;
    if (!rst) begin
      if (in_valid && in_ready) pending_verdicts.push_back(predict_verdict(candidate));
      if (out_valid && out_ready) begin
        if (pending_verdicts.size() == 0) begin
          report_mismatch("unexpected result, tested_value", 64'd0, 64'(tested_value));
        end else begin
          want = pending_verdicts.pop_front();
          if (tested_value !== want.value)
            report_mismatch("tested_value", 64'(want.value), 64'(tested_value));
          if (is_prime !== want.prime)
            report_mismatch($sformatf("is_prime of %0d", want.value),
                            64'(want.prime), 64'(is_prime));
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("trial_division_prime_test_unit regression: fail");
    $finish;
  end

  initial begin
    logic [IN_W-1:0] directed[$];
    directed = '{
      32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd15, 32'd25, 32'd49,
      32'd97, 32'd121, 32'd63001, 32'd65521, 32'd65537, 32'd1000003,
      32'd111546435, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000,
      32'hAAAA_AAAA, 32'h5555_5555
    };
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Sender mostly busy, receiver mostly stalled.
    send_idle_pct = 10;
    recv_idle_pct = 85;
    foreach (directed[i]) candidates_to_send.push_back(directed[i]);
    repeat (20) candidates_to_send.push_back(random_candidate());
    wait_until_drained();

    // Sender mostly idle, receiver mostly ready.
    send_idle_pct = 85;
    recv_idle_pct = 10;
    repeat (25) candidates_to_send.push_back(random_candidate());
    wait_until_drained();

    // No idling. A long receiver hold-off first, so results back up and the
    // input stalls while even values keep arriving.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    start_hold = 1'b1;
    @(negedge clk);
    start_hold = 1'b0;
    repeat (8) candidates_to_send.push_back(random_candidate() & {{(IN_W-1){1'b1}}, 1'b0});
    wait_until_drained();
    repeat (25) candidates_to_send.push_back(random_candidate());
    wait_until_drained();

    repeat (40) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("trial_division_prime_test_unit regression: pass");
    end else begin
      $display("trial_division_prime_test_unit regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/tdpt_pkg.sv
rtl/core/tdpt_divider.sv
rtl/core/trial_division_prime_test_unit.sv
tb/testbench.sv
